### rtl/pic_pkg.sv
// ----------------------------------------------------------------------------
// pic_pkg
// Shared constants, operation codes and types for the interrupt controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pic_pkg;

  localparam int SOURCES       = 64;
  localparam int CONTEXTS      = 2;
  localparam int PRIORITY_BITS = 3;
  localparam int WORD_BITS     = 32;
  localparam int EN_WORDS      = (SOURCES + WORD_BITS - 1) / WORD_BITS;
  localparam int SRC_W         = $clog2(SOURCES);

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_RAISE = 2'd2;

  localparam logic [2:0] SP_PRIO      = 3'd0;
  localparam logic [2:0] SP_PENDING   = 3'd1;
  localparam logic [2:0] SP_ENABLE    = 3'd2;
  localparam logic [2:0] SP_THRESHOLD = 3'd3;
  localparam logic [2:0] SP_CLAIM     = 3'd4;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_RAISE,
    OP_RD_PRIO,
    OP_RD_PEND,
    OP_RD_EN,
    OP_RD_THR,
    OP_CLAIM,
    OP_WR_PRIO,
    OP_WR_EN,
    OP_WR_THR,
    OP_COMPLETE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        ctx;
    logic [5:0]  idx;
    logic [31:0] data;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDPRIO,
    ST_START,
    ST_SCAN,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

### rtl/platform_interrupt_controller.sv
// Each request takes one source scan before its response, a priority read adds a
// read state (ST_RDPRIO), and a claim takes two scans, each over all 64 sources.
// The back end handles one request at a time and scans one source a cycle through
// the single read port of the priority store.
// A two-entry request queue lets the bus hand over requests while a result waits.
// Reset (rst, synchronous) clears priorities, pending, in-service, enables and
// thresholds at once; the block is ready in the cycle after reset.
// ----------------------------------------------------------------------------
// platform_interrupt_controller
// Interrupt controller top level: request queue front end and scan back end.
// ----------------------------------------------------------------------------
`default_nettype none

module platform_interrupt_controller
  import pic_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [2:0]  space,
  input  wire logic        context_req,
  input  wire logic [5:0]  index,
  input  wire logic [31:0] write_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      read_data,
  output logic [1:0]       irq_lines
);

  logic q_valid;
  req_t q_data;
  logic q_pop;

  pic_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .space       (space),
    .context_req (context_req),
    .index       (index),
    .write_data  (write_data),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop)
  );

  pic_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .irq_lines (irq_lines)
  );

endmodule

`default_nettype wire

### rtl/pic_front.sv
// ----------------------------------------------------------------------------
// pic_front
// Decodes each bus request into an operation and queues it for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pic_front
  import pic_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [2:0]  space,
  input  wire logic        context_req,
  input  wire logic [5:0]  index,
  input  wire logic [31:0] write_data,
  output logic             q_valid,
  output req_t             q_data,
  input  wire logic        q_pop
);

  req_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  op_t        op;
  logic       push;

  always_comb begin
    op = OP_NOP;
    case (kind)
      KIND_RAISE: op = OP_RAISE;
      KIND_READ: begin
        case (space)
          SP_PRIO:      op = OP_RD_PRIO;
          SP_PENDING:   op = OP_RD_PEND;
          SP_ENABLE:    op = OP_RD_EN;
          SP_THRESHOLD: op = OP_RD_THR;
          SP_CLAIM:     op = OP_CLAIM;
          default:      op = OP_NOP;
        endcase
      end
      KIND_WRITE: begin
        case (space)
          SP_PRIO:      op = OP_WR_PRIO;
          SP_ENABLE:    op = OP_WR_EN;
          SP_THRESHOLD: op = OP_WR_THR;
          SP_CLAIM:     op = OP_COMPLETE;
          default:      op = OP_NOP;
        endcase
      end
      default: op = OP_NOP;
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_data   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= '{op: op, ctx: context_req, idx: index, data: write_data};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

`default_nettype wire

### rtl/pic_back.sv
// ----------------------------------------------------------------------------
// pic_back
// Carries out queued requests: state updates, reads, and the serial source
// scan that finds claim winners and the interrupt lines.
// ----------------------------------------------------------------------------
`default_nettype none

module pic_back
  import pic_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  input  wire req_t                q_data,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [31:0]              read_data,
  output logic [CONTEXTS-1:0]      irq_lines
);

  state_t state;
  state_t state_next;

  req_t   cur;

  // priority store with per-entry valid bits
  logic [PRIORITY_BITS-1:0] prio_mem [SOURCES];
  logic [SOURCES-1:0]       prio_vld;
  logic [SRC_W-1:0]         raddr;
  logic [PRIORITY_BITS-1:0] rdata_raw;
  logic                     rdata_vld;
  logic [PRIORITY_BITS-1:0] rdata;

  logic [SOURCES-1:0]       pend;
  logic [SOURCES-1:0]       insv;
  logic [SOURCES-1:0]       en [CONTEXTS];
  logic [PRIORITY_BITS-1:0] thr [CONTEXTS];

  logic [SRC_W-1:0]         cnt;
  logic                     issuing;
  logic [SRC_W-1:0]         s_q;
  logic                     chk;
  logic                     last_chk;
  logic [SRC_W-1:0]         best_id [CONTEXTS];
  logic [PRIORITY_BITS-1:0] best_pr [CONTEXTS];
  logic                     claim_phase;
  logic                     pass_end;

  logic [31:0]              rd;
  logic [CONTEXTS-1:0]      irq;

  assign rdata     = rdata_vld ? rdata_raw : '0;
  // end the pass in the cycle after the last source has been compared
  assign pass_end  = last_chk;
  assign out_valid = (state == ST_RESP);
  assign read_data = rd;
  assign irq_lines = irq;

  always_comb begin
    raddr = cnt;
    if (state == ST_EXEC) raddr = cur.idx[SRC_W-1:0];
  end

  always_ff @(posedge clk) begin
    rdata_raw <= prio_mem[raddr];
    rdata_vld <= prio_vld[raddr];
    if (state == ST_EXEC && cur.op == OP_WR_PRIO && cur.idx != '0) begin
      prio_mem[cur.idx[SRC_W-1:0]] <= cur.data[PRIORITY_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC:   state_next = (cur.op == OP_RD_PRIO) ? ST_RDPRIO : ST_START;
      ST_RDPRIO: state_next = ST_START;
      ST_START:  state_next = ST_SCAN;
      ST_SCAN: begin
        if (pass_end) state_next = claim_phase ? ST_START : ST_RESP;
      end
      ST_RESP: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      prio_vld <= '0;
      pend     <= '0;
      insv     <= '0;
      for (int c = 0; c < CONTEXTS; c++) begin
        en[c]  <= '0;
        thr[c] <= '0;
      end
      issuing     <= 1'b0;
      chk         <= 1'b0;
      last_chk    <= 1'b0;
      claim_phase <= 1'b0;
    end else begin
      chk      <= issuing;
      last_chk <= chk && (s_q == SRC_W'(SOURCES - 1));
      if (state == ST_IDLE && q_valid) begin
        claim_phase <= (q_data.op == OP_CLAIM);
      end
      if (state == ST_EXEC) begin
        case (cur.op)
          OP_RAISE: begin
            if (cur.idx != '0 && !pend[cur.idx[SRC_W-1:0]] && !insv[cur.idx[SRC_W-1:0]])
              pend[cur.idx[SRC_W-1:0]] <= 1'b1;
          end
          OP_WR_PRIO: begin
            if (cur.idx != '0) prio_vld[cur.idx[SRC_W-1:0]] <= 1'b1;
          end
          OP_WR_EN: begin
            for (int w = 0; w < EN_WORDS; w++) begin
              if (cur.idx == 6'(w)) begin
                en[cur.ctx][w*WORD_BITS +: WORD_BITS] <=
                  (w == 0) ? (cur.data & ~32'd1) : cur.data;
              end
            end
          end
          OP_WR_THR: thr[cur.ctx] <= cur.data[PRIORITY_BITS-1:0];
          OP_COMPLETE: begin
            if (cur.data != '0 && cur.data < 32'(SOURCES)
                && en[cur.ctx][cur.data[SRC_W-1:0]])
              insv[cur.data[SRC_W-1:0]] <= 1'b0;
          end
          default: ;
        endcase
      end
      if (state == ST_START) begin
        issuing <= 1'b1;
      end else if (issuing && cnt == SRC_W'(SOURCES - 1)) begin
        issuing <= 1'b0;
      end
      if (state == ST_SCAN && pass_end && claim_phase) begin
        claim_phase <= 1'b0;
        if (best_id[cur.ctx] != '0) begin
          pend[best_id[cur.ctx]] <= 1'b0;
          insv[best_id[cur.ctx]] <= 1'b1;
        end
      end
    end
  end

  // payload and scan datapath
  always_ff @(posedge clk) begin
    s_q <= cnt;
    if (state == ST_IDLE && q_valid) cur <= q_data;
    if (issuing) cnt <= cnt + 1'b1;
    if (state == ST_EXEC) begin
      rd <= '0;
      case (cur.op)
        OP_RD_PEND: begin
          for (int w = 0; w < EN_WORDS; w++)
            if (cur.idx == 6'(w)) rd <= pend[w*WORD_BITS +: WORD_BITS];
        end
        OP_RD_EN: begin
          for (int w = 0; w < EN_WORDS; w++)
            if (cur.idx == 6'(w)) rd <= en[cur.ctx][w*WORD_BITS +: WORD_BITS];
        end
        OP_RD_THR: rd <= 32'(thr[cur.ctx]);
        default: ;
      endcase
    end
    if (state == ST_RDPRIO && cur.idx != '0) rd <= 32'(rdata);
    if (state == ST_START) begin
      cnt <= '0;
      for (int c = 0; c < CONTEXTS; c++) begin
        best_id[c] <= '0;
        best_pr[c] <= thr[c];
      end
    end
    if (chk && s_q != '0) begin
      for (int c = 0; c < CONTEXTS; c++) begin
        if (pend[s_q] && en[c][s_q] && rdata > best_pr[c]) begin
          best_id[c] <= s_q;
          best_pr[c] <= rdata;
        end
      end
    end
    if (state == ST_SCAN && pass_end) begin
      if (claim_phase) begin
        rd <= 32'(best_id[cur.ctx]);
      end else begin
        for (int c = 0; c < CONTEXTS; c++) irq[c] <= (best_id[c] != '0);
      end
    end
  end

endmodule

`default_nettype wire
